FILE: rtl/edg_pkg.sv
// ----------------------------------------------------------------------------
// edg_pkg
// Shared types, codes and helpers for the embedding dot / gradient table unit.
// ----------------------------------------------------------------------------
package edg_pkg;

  // default geometry
  localparam int unsigned ROWS_DEF = 1024;
  localparam int unsigned COLS_DEF = 64;

  // reset value of the column count register
  localparam logic [6:0] CFG_COLS_RST = 7'd64;

  // command queue depth between front and back (power of two)
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPW    = $clog2(QDEPTH);

  // op codes
  localparam logic [2:0] OP_DOT    = 3'd0;
  localparam logic [2:0] OP_ACC    = 3'd1;
  localparam logic [2:0] OP_COMMIT = 3'd2;
  localparam logic [2:0] OP_GET    = 3'd3;
  localparam logic [2:0] OP_LOAD   = 3'd4;

  // one classified command word
  typedef struct packed {
    logic [2:0]         op;
    logic [9:0]         src;    // already reduced modulo ROWS
    logic [9:0]         dst;
    logic signed [15:0] scale;
    logic [5:0]         col;
    logic               sel;
    logic signed [15:0] lval;
    logic [6:0]         ncols;  // effective column count, 1..COLS
  } edg_cmd_t;

  // back to front control
  typedef struct packed {
    logic clearing;
    logic pop;
  } edg_ctl_t;

  // saturate a 21-bit signed sum to Q4.12
  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    logic signed [15:0] r;
    if (v > 21'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -21'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/edg_front.sv
// ----------------------------------------------------------------------------
// edg_front
// Takes input words, holds the column register, drops no-op words, reduces row
// indexes and queues commands for the back end.
// ----------------------------------------------------------------------------
module edg_front #(
  parameter int unsigned ROWS = edg_pkg::ROWS_DEF,
  parameter int unsigned COLS = edg_pkg::COLS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          op_i,
  input  logic [9:0]          src_row_i,
  input  logic [9:0]          dst_row_i,
  input  logic signed [15:0]  scale_i,
  input  logic [5:0]          col_i,
  input  logic                table_sel_i,
  input  logic signed [15:0]  load_value_i,
  output logic                cmd_valid_o,
  output edg_pkg::edg_cmd_t   cmd_o,
  input  edg_pkg::edg_ctl_t   ctl_i
);

  logic [6:0]              cols_q;
  logic [6:0]              ncols;
  logic                    keep;
  logic                    push;
  edg_pkg::edg_cmd_t       cmd;
  edg_pkg::edg_cmd_t       q_mem [edg_pkg::QDEPTH];
  logic [edg_pkg::QPW-1:0] wr_q, rd_q;
  logic [edg_pkg::QPW:0]   cnt_q, cnt_d;

  // row index modulo ROWS by conditional subtraction of ROWS shifted left, largest shift first
  function automatic logic [9:0] row_mod(input logic [9:0] r);
    logic [9:0] x;
    x = r;
    for (int k = 9; k >= 0; k--) begin
      if ((64'(ROWS) << k) < 64'd1024) begin
        if (64'(x) >= (64'(ROWS) << k)) begin
          x = x - 10'(64'(ROWS) << k);
        end
      end
    end
    return x;
  endfunction

  // column count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= edg_pkg::CFG_COLS_RST;
    end else if (cfg_we_i) begin
      cols_q <= cfg_wdata_i;
    end
  end

  // effective column count, clamped to 1..COLS
  always_comb begin
    if (cols_q == 7'd0) begin
      ncols = 7'd1;
    end else if (cols_q > 7'(COLS)) begin
      ncols = 7'(COLS);
    end else begin
      ncols = cols_q;
    end
  end

  // classify: unknown ops and loads past the last column do nothing
  always_comb begin
    keep = (op_i == edg_pkg::OP_DOT) || (op_i == edg_pkg::OP_ACC) ||
           (op_i == edg_pkg::OP_COMMIT) || (op_i == edg_pkg::OP_GET) ||
           ((op_i == edg_pkg::OP_LOAD) && (7'(col_i) < 7'(COLS)));
    cmd.op    = op_i;
    cmd.src   = row_mod(src_row_i);
    cmd.dst   = row_mod(dst_row_i);
    cmd.scale = scale_i;
    cmd.col   = col_i;
    cmd.sel   = table_sel_i;
    cmd.lval  = load_value_i;
    cmd.ncols = ncols;
  end

  assign in_stall_o = (cnt_q == (edg_pkg::QPW+1)'(edg_pkg::QDEPTH)) || ctl_i.clearing;
  assign push       = in_valid_i && !in_stall_o && keep;

  // command queue
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= cmd;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !ctl_i.pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && ctl_i.pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // pointers wrap naturally, depth is a power of two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (ctl_i.pop) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_q];

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> cnt_q != (edg_pkg::QPW+1)'(edg_pkg::QDEPTH))
    else $error("push into full command queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.pop |-> cnt_q != '0)
    else $error("pop from empty command queue");
  a_stall_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clearing |-> in_stall_o)
    else $error("input taken during clearing pass");
`endif

endmodule

FILE: rtl/edg_back.sv
// ----------------------------------------------------------------------------
// edg_back
// Table memories, sequencer and three-stage datapath (read, multiply,
// accumulate / write back), plus the result register.
// ----------------------------------------------------------------------------
module edg_back #(
  parameter int unsigned ROWS = edg_pkg::ROWS_DEF,
  parameter int unsigned COLS = edg_pkg::COLS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  edg_pkg::edg_cmd_t   cmd_i,
  output edg_pkg::edg_ctl_t   ctl_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  value_o,
  output logic                last_o
);

  localparam int unsigned SIZE = ROWS * COLS;
  localparam int unsigned AW   = $clog2(SIZE);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SETUP  = 4'd2;
  localparam logic [3:0] S_RUN    = 4'd3;
  localparam logic [3:0] S_DRAIN  = 4'd4;
  localparam logic [3:0] S_OUT    = 4'd5;
  localparam logic [3:0] S_GET_RD = 4'd6;
  localparam logic [3:0] S_GET_WR = 4'd7;
  localparam logic [3:0] S_LOAD   = 4'd8;

  logic signed [15:0] in_table  [SIZE];
  logic signed [15:0] out_table [SIZE];
  logic signed [15:0] in_grad   [SIZE];
  logic signed [15:0] out_grad  [SIZE];

  logic [3:0]          state_q, state_d;
  edg_pkg::edg_cmd_t   cmd_q;
  logic [AW-1:0]       sbase_q, dbase_q;
  logic [6:0]          col_q, col_d;
  logic [AW-1:0]       lin_q, lin_d;
  logic                last_issue;

  // read side
  logic                rd_en;
  logic [AW-1:0]       ra_src, ra_dst;
  logic signed [15:0]  rd_it_q, rd_ot_q, rd_ig_q, rd_og_q;

  // pipeline
  logic                p1_v_q, p2_v_q;
  logic [AW-1:0]       p1_sa_q, p1_da_q, p2_sa_q, p2_da_q;
  logic signed [31:0]  m0, m1, p2_m0_q, p2_m1_q;
  logic signed [15:0]  p2_it_q, p2_ot_q, p2_ig_q, p2_og_q;
  logic signed [39:0]  acc_q;
  logic signed [19:0]  g_in, g_out;

  // write side
  logic                it_we, ot_we, ig_we, og_we;
  logic [AW-1:0]       it_wa, ot_wa, ig_wa, og_wa;
  logic signed [15:0]  it_wd, ot_wd, ig_wd, og_wd;

  // result register
  logic                out_free;
  logic                out_ld;
  logic signed [31:0]  out_val;
  logic                out_last;
  logic                out_valid_q;
  logic signed [31:0]  value_q;
  logic                last_q;

  assign out_free = !out_valid_q || !out_stall_i;

  assign last_issue = (cmd_q.op == edg_pkg::OP_COMMIT) ? (lin_q == AW'(SIZE - 1))
                                                       : (col_q == cmd_q.ncols - 7'd1);

  // sequencer
  always_comb begin
    state_d  = state_q;
    col_d    = col_q;
    lin_d    = lin_q;
    rd_en    = 1'b0;
    ra_src   = sbase_q + AW'(col_q);
    ra_dst   = dbase_q + AW'(col_q);
    ctl_o    = '0;
    out_ld   = 1'b0;
    out_val  = '0;
    out_last = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        ctl_o.clearing = 1'b1;
        lin_d = lin_q + 1'b1;
        if (lin_q == AW'(SIZE - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          ctl_o.pop = 1'b1;
          state_d   = S_SETUP;
        end
      end
      S_SETUP: begin
        col_d = '0;
        lin_d = '0;
        priority case (cmd_q.op)
          edg_pkg::OP_GET:  state_d = S_GET_RD;
          edg_pkg::OP_LOAD: state_d = S_LOAD;
          default:          state_d = S_RUN;
        endcase
      end
      S_RUN: begin
        rd_en = 1'b1;
        if (cmd_q.op == edg_pkg::OP_COMMIT) begin
          ra_src = lin_q;
          ra_dst = lin_q;
        end
        col_d = col_q + 7'd1;
        lin_d = lin_q + 1'b1;
        if (last_issue) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!p1_v_q && !p2_v_q) begin
          state_d = (cmd_q.op == edg_pkg::OP_ACC) ? S_IDLE : S_OUT;
        end
      end
      S_OUT: begin
        // dot: floor shift by 12; 64 products of Q4.12 never leave 32 bits
        out_val = (cmd_q.op == edg_pkg::OP_DOT) ? 32'($signed(acc_q[39:12])) : '0;
        if (out_free) begin
          out_ld  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_GET_RD: begin
        rd_en   = 1'b1;
        state_d = S_GET_WR;
      end
      S_GET_WR: begin
        out_val  = 32'(rd_it_q);
        out_last = (col_q == cmd_q.ncols - 7'd1);
        if (out_free) begin
          out_ld = 1'b1;
          col_d  = col_q + 7'd1;
          state_d = out_last ? S_IDLE : S_GET_RD;
        end
      end
      S_LOAD: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      lin_q   <= '0;
      col_q   <= '0;
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      lin_q   <= lin_d;
      col_q   <= col_d;
      p1_v_q  <= (state_q == S_RUN);
      p2_v_q  <= p1_v_q;
    end
  end

  // command and row bases
  always_ff @(posedge clk_i) begin
    if (ctl_o.pop) begin
      cmd_q <= cmd_i;
    end
    if (state_q == S_SETUP) begin
      sbase_q <= AW'(cmd_q.src) * AW'(COLS);
      dbase_q <= AW'(cmd_q.dst) * AW'(COLS);
    end
  end

  // stage 1: products
  assign m0 = ((cmd_q.op == edg_pkg::OP_ACC) ? cmd_q.scale : rd_it_q) * rd_ot_q;
  assign m1 = cmd_q.scale * rd_it_q;

  always_ff @(posedge clk_i) begin
    p1_sa_q <= ra_src;
    p1_da_q <= ra_dst;
    p2_sa_q <= p1_sa_q;
    p2_da_q <= p1_da_q;
    p2_m0_q <= m0;
    p2_m1_q <= m1;
    p2_it_q <= rd_it_q;
    p2_ot_q <= rd_ot_q;
    p2_ig_q <= rd_ig_q;
    p2_og_q <= rd_og_q;
  end

  // stage 2: dot accumulator
  always_ff @(posedge clk_i) begin
    if (state_q == S_SETUP) begin
      acc_q <= '0;
    end else if (p2_v_q && (cmd_q.op == edg_pkg::OP_DOT)) begin
      acc_q <= acc_q + 40'(p2_m0_q);
    end
  end

  // floored Q8.12 gradient terms
  assign g_in  = $signed(p2_m0_q[31:12]);
  assign g_out = $signed(p2_m1_q[31:12]);

  // stage 2: write back, plus load and clearing writes
  always_comb begin
    it_we = 1'b0; ot_we = 1'b0; ig_we = 1'b0; og_we = 1'b0;
    it_wa = p2_sa_q; ig_wa = p2_sa_q;
    ot_wa = p2_da_q; og_wa = p2_da_q;
    it_wd = edg_pkg::sat16(21'(p2_it_q) + 21'(p2_ig_q));
    ot_wd = edg_pkg::sat16(21'(p2_ot_q) + 21'(p2_og_q));
    ig_wd = edg_pkg::sat16(21'(p2_ig_q) + 21'(g_in));
    og_wd = edg_pkg::sat16(21'(p2_og_q) + 21'(g_out));
    if (state_q == S_CLEAR) begin
      ig_we = 1'b1; og_we = 1'b1;
      ig_wa = lin_q; og_wa = lin_q;
      ig_wd = '0;    og_wd = '0;
    end else if (state_q == S_LOAD) begin
      it_we = !cmd_q.sel;
      ot_we = cmd_q.sel;
      it_wa = sbase_q + AW'(cmd_q.col);
      ot_wa = dbase_q + AW'(cmd_q.col);
      it_wd = cmd_q.lval;
      ot_wd = cmd_q.lval;
    end else if (p2_v_q && (cmd_q.op == edg_pkg::OP_ACC)) begin
      ig_we = 1'b1; og_we = 1'b1;
    end else if (p2_v_q && (cmd_q.op == edg_pkg::OP_COMMIT)) begin
      it_we = 1'b1; ot_we = 1'b1; ig_we = 1'b1; og_we = 1'b1;
      ig_wd = '0;   og_wd = '0;
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (it_we) begin
      in_table[it_wa] <= it_wd;
    end
    if (rd_en) begin
      rd_it_q <= in_table[ra_src];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ot_we) begin
      out_table[ot_wa] <= ot_wd;
    end
    if (rd_en) begin
      rd_ot_q <= out_table[ra_dst];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ig_we) begin
      in_grad[ig_wa] <= ig_wd;
    end
    if (rd_en) begin
      rd_ig_q <= in_grad[ra_src];
    end
  end

  always_ff @(posedge clk_i) begin
    if (og_we) begin
      out_grad[og_wa] <= og_wd;
    end
    if (rd_en) begin
      rd_og_q <= out_grad[ra_dst];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      value_q <= out_val;
      last_q  <= out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !ctl_o.pop)
    else $error("command taken during clearing pass");
  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_v_q |-> $past(p1_v_q))
    else $error("stage 2 valid without stage 1");
  a_out_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (!p1_v_q && !p2_v_q))
    else $error("result sent before pipeline drained");
`endif

endmodule

FILE: rtl/embedding_dot_and_gradient_table_unit.sv
// ----------------------------------------------------------------------------
// embedding_dot_and_gradient_table_unit
// Embedding tables with gradient buffers: dot, accumulate, commit, get, load.
// ----------------------------------------------------------------------------
// After reset the unit sweeps both gradient memories to zero, one entry a
// cycle, and takes no word meanwhile. Every table memory has one read and one
// write port, which sets the pace: dot and accumulate walk the active columns,
// get reads and sends one element at a time, load writes one entry, and commit
// walks the whole table. The front queues up to two commands, so input words
// are taken while the back end works and while a result waits to be taken, as
// long as the queue has room.
module embedding_dot_and_gradient_table_unit #(
  parameter int unsigned ROWS = edg_pkg::ROWS_DEF,
  parameter int unsigned COLS = edg_pkg::COLS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic [9:0]         src_row_i,
  input  logic [9:0]         dst_row_i,
  input  logic signed [15:0] scale_i,
  input  logic [5:0]         col_i,
  input  logic               table_sel_i,
  input  logic signed [15:0] load_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic               last_o
);

  logic              cmd_valid;
  edg_pkg::edg_cmd_t cmd;
  edg_pkg::edg_ctl_t ctl;

  edg_front #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .src_row_i   (src_row_i),
    .dst_row_i   (dst_row_i),
    .scale_i     (scale_i),
    .col_i       (col_i),
    .table_sel_i (table_sel_i),
    .load_value_i(load_value_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .ctl_i       (ctl)
  );

  edg_back #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .ctl_o      (ctl),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .value_o    (value_o),
    .last_o     (last_o)
  );

endmodule
